>>> design/fud_pkg.sv
// package for the url form decoder: event and error codes, result struct,
// character constants and the hex digit helper; no dependencies
`default_nettype none

package fud_pkg;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_NAME_BYTE  = 3'd1,
        EV_NAME_END   = 3'd2,
        EV_VALUE_BYTE = 3'd3,
        EV_VALUE_END  = 3'd4,
        EV_ERROR      = 3'd5
    } fud_event_t;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_SEP   = 3'd1,
        ERR_QUOTE = 3'd2,
        ERR_LONG  = 3'd3,
        ERR_HEX   = 3'd4,
        ERR_END   = 3'd5
    } fud_error_t;

    typedef struct packed {
        fud_event_t ev;
        logic [7:0] data;
        fud_error_t err;
    } fud_result_t;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h61 + 8'd10)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h41 + 8'd10)};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/fud_core.sv
// decoder state registers and the per-character decode logic
// depends on fud_pkg
`default_nettype none

module fud_core #(
    parameter int MAX_NAME_LEN = 255
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  step,
    input  wire                  kind,
    input  wire [7:0]            data_byte,
    output fud_pkg::fud_result_t result
);
    import fud_pkg::*;

    localparam int NL_W = $clog2(MAX_NAME_LEN + 1);
    localparam logic [NL_W-1:0] LEN_MAX = NL_W'(MAX_NAME_LEN);

    logic            in_name_reg,  in_name_next;
    logic            esc_reg,      esc_next;
    logic            digit_reg,    digit_next;
    logic [3:0]      hi_reg,       hi_next;
    logic [NL_W-1:0] len_reg,      len_next;
    logic            failed_reg,   failed_next;

    logic [4:0] hv;
    logic [7:0] dec_byte;

    assign hv       = hex_value(data_byte);
    assign dec_byte = {hi_reg, hv[3:0]};

    always_comb begin
        in_name_next = in_name_reg;
        esc_next     = esc_reg;
        digit_next   = digit_reg;
        hi_next      = hi_reg;
        len_next     = len_reg;
        failed_next  = failed_reg;
        result       = '{ev: EV_NONE, data: 8'h00, err: ERR_OK};

        if (kind) begin
            in_name_next = 1'b1;
            esc_next     = 1'b0;
            digit_next   = 1'b0;
            hi_next      = 4'h0;
            len_next     = '0;
            failed_next  = 1'b0;
            if (failed_reg) begin
                result.ev = EV_NONE;
            end else if (in_name_reg || esc_reg) begin
                result.ev  = EV_ERROR;
                result.err = ERR_END;
            end else begin
                result.ev = EV_VALUE_END;
            end
        end else if (failed_reg) begin
            result.ev = EV_NONE;
        end else if (esc_reg) begin
            if (hv[4]) begin
                failed_next = 1'b1;
                result.ev   = EV_ERROR;
                result.err  = ERR_HEX;
            end else if (!digit_reg) begin
                hi_next    = hv[3:0];
                digit_next = 1'b1;
            end else begin
                esc_next   = 1'b0;
                digit_next = 1'b0;
                hi_next    = 4'h0;
                // decoded carriage return is dropped
                if (dec_byte != CH_CR) begin
                    result.ev   = EV_VALUE_BYTE;
                    result.data = dec_byte;
                end
            end
        end else begin
            priority if (data_byte == CH_AMP) begin
                if (in_name_reg) begin
                    failed_next = 1'b1;
                    result.ev   = EV_ERROR;
                    result.err  = ERR_SEP;
                end else begin
                    in_name_next = 1'b1;
                    len_next     = '0;
                    result.ev    = EV_VALUE_END;
                end
            end else if (data_byte == CH_PLUS) begin
                if (in_name_reg) begin
                    failed_next = 1'b1;
                    result.ev   = EV_ERROR;
                    result.err  = ERR_SEP;
                end else begin
                    result.ev   = EV_VALUE_BYTE;
                    result.data = CH_SPACE;
                end
            end else if (data_byte == CH_EQ) begin
                if (in_name_reg) begin
                    in_name_next = 1'b0;
                    result.ev    = EV_NAME_END;
                end else begin
                    result.ev   = EV_VALUE_BYTE;
                    result.data = data_byte;
                end
            end else if (data_byte == CH_PCT) begin
                if (in_name_reg) begin
                    failed_next = 1'b1;
                    result.ev   = EV_ERROR;
                    result.err  = ERR_SEP;
                end else begin
                    esc_next   = 1'b1;
                    digit_next = 1'b0;
                end
            end else if (data_byte == CH_SQUOT || data_byte == CH_DQUOT) begin
                failed_next = 1'b1;
                result.ev   = EV_ERROR;
                result.err  = ERR_QUOTE;
            end else if (in_name_reg) begin
                if (len_reg >= LEN_MAX) begin
                    failed_next = 1'b1;
                    result.ev   = EV_ERROR;
                    result.err  = ERR_LONG;
                end else begin
                    len_next    = len_reg + 1'b1;
                    result.ev   = EV_NAME_BYTE;
                    result.data = data_byte;
                end
            end else begin
                result.ev   = EV_VALUE_BYTE;
                result.data = data_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_name_reg <= 1'b1;
            esc_reg     <= 1'b0;
            digit_reg   <= 1'b0;
            hi_reg      <= 4'h0;
            len_reg     <= '0;
            failed_reg  <= 1'b0;
        end else if (step) begin
            in_name_reg <= in_name_next;
            esc_reg     <= esc_next;
            digit_reg   <= digit_next;
            hi_reg      <= hi_next;
            len_reg     <= len_next;
            failed_reg  <= failed_next;
        end
    end

    ap_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX)
        else $error("name length past limit");

    ap_digit_needs_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_reg |-> esc_reg)
        else $error("digit flag without escape");

    ap_esc_not_in_name: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> !in_name_reg)
        else $error("escape open inside a name");

endmodule

`default_nettype wire

>>> design/form_urlencoded_decoder_unit.sv
// Form urlencoded decoder: takes one encoded character (or an end of stream
// marker) per request and returns exactly one result per request. A request
// is captured in the input register, decoded by short combinational logic and
// loaded into the output register once that register is empty or being
// taken, where its result sits until taken. A new request can be accepted
// every cycle while results drain, so the sustained rate is one request per
// clock. A waiting result stalls the input only once the input register is
// full as well. Errors on a character latch the decoder silent until the
// next end of stream marker.
// depends on fud_pkg and fud_core
`default_nettype none

module form_urlencoded_decoder_unit #(
    parameter int MAX_NAME_LEN = 255
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire         s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic [2:0]  m_tuser    // [2:0] event_res
);
    import fud_pkg::*;

    logic        in_valid_reg;
    logic        kind_reg;
    logic [7:0]  byte_reg;
    logic        out_valid_reg;
    fud_result_t out_reg;
    fud_result_t result;
    logic        load_out;

    assign load_out = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            kind_reg <= s_tuser;
            byte_reg <= s_tdata;
        end
    end

    fud_core #(
        .MAX_NAME_LEN(MAX_NAME_LEN)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (load_out),
        .kind      (kind_reg),
        .data_byte (byte_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.ev;
    assign m_tdata  = {5'b0, out_reg.err, out_reg.data};

    ap_err_only_with_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_reg.ev == EV_ERROR) == (out_reg.err != ERR_OK)))
        else $error("error code does not match event");

    ap_byte_only_with_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.ev != EV_NAME_BYTE && out_reg.ev != EV_VALUE_BYTE)
        |-> (out_reg.data == 8'h00))
        else $error("byte set on a non-data event");

    ap_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg || !in_valid_reg) |-> s_tready)
        else $error("input stalled with room downstream");

    ap_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid)
        else $error("decoded request did not reach output");

endmodule

`default_nettype wire
